>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the palette converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a consequence holds in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// Types and constants shared by the palette pixel converter modules.
// ----------------------------------------------------------------------------
package ppc_pkg;

   // Default palette depth.
   localparam int PALETTE_ENTRIES_DEFAULT = 256;

   // Field widths.
   localparam int INDEX_W = 8;
   localparam int LEVEL_W = 6;
   localparam int PIXEL_W = 32;

   // Configuration register indexes (selected by address bit 2).
   localparam logic CSR_COLOR_MODE = 1'b0;
   localparam logic CSR_SWAP_BYTES = 1'b1;

   // Item kinds on the request channel.
   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_PIXEL = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   // Pixel formats.
   typedef enum logic [2:0] {
      MODE_INDEXED = 3'd0,
      MODE_RGB555  = 3'd1,
      MODE_RGB565  = 3'd2,
      MODE_BGR24   = 3'd3,
      MODE_XRGB32  = 3'd4
   } mode_type;

   // Classified command handed from the front end to the back end.
   typedef struct packed {
      kind_type            kind;
      logic                in_range;
      logic [INDEX_W-1:0]  index;
      logic [LEVEL_W-1:0]  red;
      logic [LEVEL_W-1:0]  green;
      logic [LEVEL_W-1:0]  blue;
   } cmd_type;

   // Command queue status.
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // One result item.
   typedef struct packed {
      logic [LEVEL_W-1:0] blue;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] red;
      logic [PIXEL_W-1:0] pixel;
   } result_type;

endpackage

>>> src/palette_pixel_converter_core.sv
// ----------------------------------------------------------------------------
// palette_pixel_converter_core
// Palette store with pixel conversion to several display formats.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ stream: tuser carries the kind (palette write,
// pixel conversion or palette read), tdata the index and the three levels.
// A write updates one palette entry and returns nothing; a pixel or a read
// returns one transaction on the rsp_ stream. Writes, reads and pixels are
// carried out strictly in arrival order, so a read right after a write to
// the same entry sees the new levels.
// The block takes one transaction per cycle while req_tready is high.
// After its request is accepted, a result passes through the command queue,
// the registered palette memory read and the output register.
// When rsp_tready is low, the output register, the lookup stage and the
// two-entry command queue fill, after which req_tready drops.
// Reset empties the pipeline, sets color_mode and swap_bytes to zero and
// marks every palette entry as zero at once; no clearing pass is needed.
// The csr_ port holds color_mode at address 0 and swap_bytes at address 4;
// change them only while no transaction is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module palette_pixel_converter_core
   import ppc_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // entry_index[7:0], red_level[13:8],
                                   // green_level[19:14], blue_level[25:20]
   input  logic [1:0]  req_tuser,  // kind[1:0]
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // pixel_value[31:0], read_red[37:32],
                                   // read_green[43:38], read_blue[49:44]
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [2:0]       color_mode_ff, color_mode_in;
   logic             swap_bytes_ff, swap_bytes_in;
   logic             csr_write;

   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   result_type       rsp_result;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      color_mode_in = color_mode_ff;
      swap_bytes_in = swap_bytes_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            CSR_COLOR_MODE: color_mode_in = csr_pwdata[2:0];
            CSR_SWAP_BYTES: swap_bytes_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= 3'd0;
         swap_bytes_ff <= 1'b0;
      end else begin
         color_mode_ff <= color_mode_in;
         swap_bytes_ff <= swap_bytes_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_SWAP_BYTES) ? {31'd0, swap_bytes_ff}
                                                        : {29'd0, color_mode_ff};

   // Front end: accept and classify.
   ppc_front #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_index  (req_tdata[7:0]),
      .req_red    (req_tdata[13:8]),
      .req_green  (req_tdata[19:14]),
      .req_blue   (req_tdata[25:20]),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   // Command queue.
   ppc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   // Back end: palette access and formatting.
   ppc_back #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .color_mode (color_mode_ff),
      .swap_bytes (swap_bytes_ff),
      .q_status   (q_status),
      .q_cmd      (head_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {6'd0, rsp_result};

   // A result carries either a pixel word or palette levels, never both.
   `ASSERT_ALWAYS(a_result_exclusive, clock, reset, !(rsp_tvalid && rsp_tdata[31:0] != 32'd0 && rsp_tdata[49:32] != 18'd0), "result holds both a pixel and levels")
   // The back end never takes a command from an empty queue.
   `ASSERT_ALWAYS(a_no_pop_empty, clock, reset, !(q_pop && q_status.empty), "pop from empty command queue")
   // A pushed command is in the queue on the next cycle.
   `ASSERT_NEXT(a_push_visible, clock, reset, q_push, !q_status.empty, "pushed command lost")

endmodule

>>> src/ppc_front.sv
// ----------------------------------------------------------------------------
// ppc_front
// Accepts request transactions, drops unused kinds and tags each command
// with whether its index falls inside the palette.
// ----------------------------------------------------------------------------
module ppc_front
   import ppc_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          req_kind,
   input  logic [INDEX_W-1:0]  req_index,
   input  logic [LEVEL_W-1:0]  req_red,
   input  logic [LEVEL_W-1:0]  req_green,
   input  logic [LEVEL_W-1:0]  req_blue,
   input  queue_status_type    q_status,
   output logic                q_push,
   output cmd_type             q_cmd
);

   logic known_kind;

   // Only the three defined kinds enter the queue; the others are consumed.
   always_comb begin
      case (kind_type'(req_kind))
         KIND_WRITE, KIND_PIXEL, KIND_READ: known_kind = 1'b1;
         default: known_kind = 1'b0;
      endcase
   end

   assign req_tready = !q_status.full;
   assign q_push     = req_tvalid && !q_status.full && known_kind;

   // Build the command.
   always_comb begin
      q_cmd.kind     = kind_type'(req_kind);
      q_cmd.in_range = ({24'd0, req_index} < 32'(PALETTE_ENTRIES));
      q_cmd.index    = req_index;
      q_cmd.red      = req_red;
      q_cmd.green    = req_green;
      q_cmd.blue     = req_blue;
   end

endmodule

>>> src/ppc_queue.sv
// ----------------------------------------------------------------------------
// ppc_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ppc_queue
   import ppc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          head_cmd,
   output queue_status_type status
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd     = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'd2);

endmodule

>>> src/ppc_back.sv
// ----------------------------------------------------------------------------
// ppc_back
// Executes queued commands against the palette memory and formats results
// into the output register.
// ----------------------------------------------------------------------------
module ppc_back
   import ppc_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [2:0]       color_mode,
   input  logic             swap_bytes,
   input  queue_status_type q_status,
   input  cmd_type          q_cmd,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output result_type       rsp_result
);

   localparam int ADDR_W  = $clog2(PALETTE_ENTRIES);
   localparam int ENTRY_W = 3 * LEVEL_W;

   logic [ENTRY_W-1:0] palette_mem_ff [PALETTE_ENTRIES];
   logic               entry_valid_ff [PALETTE_ENTRIES];

   logic               s1_valid_ff, s1_valid_in;
   kind_type           s1_kind_ff;
   logic [INDEX_W-1:0] s1_index_ff;
   logic               s1_hit_ff;
   logic [ENTRY_W-1:0] s1_entry_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff, rsp_data_in;

   logic [ADDR_W-1:0]  addr;
   logic               is_write;
   logic               do_write;
   logic               out_ready;
   logic               s1_ready;
   logic [ENTRY_W-1:0] levels;

   // Convert one palette entry into a display word.
   function automatic logic [PIXEL_W-1:0] convert(
      input logic [2:0]         mode,
      input logic               swap,
      input logic [INDEX_W-1:0] idx,
      input logic [LEVEL_W-1:0] r,
      input logic [LEVEL_W-1:0] g,
      input logic [LEVEL_W-1:0] b
   );
      logic [15:0]        w16;
      logic [PIXEL_W-1:0] w32;
      logic [PIXEL_W-1:0] res;
      w16 = 16'd0;
      w32 = {8'd0, r, 2'b00, g, 2'b00, b, 2'b00};
      case (mode_type'(mode))
         MODE_INDEXED: res = {24'd0, idx};
         MODE_RGB555: begin
            w16 = {1'b0, r[5:1], g[5:1], b[5:1]};
            res = swap ? {16'd0, w16[7:0], w16[15:8]} : {16'd0, w16};
         end
         MODE_RGB565: begin
            w16 = {r[5:1], g, b[5:1]};
            res = swap ? {16'd0, w16[7:0], w16[15:8]} : {16'd0, w16};
         end
         MODE_BGR24: res = w32;
         MODE_XRGB32: begin
            res = swap ? {w32[7:0], w32[15:8], w32[23:16], w32[31:24]} : w32;
         end
         default: res = '0;
      endcase
      return res;
   endfunction

   // Handshake between the stages.
   assign out_ready = !rsp_valid_ff || rsp_tready;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign q_pop     = !q_status.empty && s1_ready;
   assign addr      = q_cmd.index[ADDR_W-1:0];
   assign is_write  = (q_cmd.kind == KIND_WRITE);
   assign do_write  = q_pop && is_write && q_cmd.in_range;

   // Palette memory: one write or one registered read per command.
   always_ff @(posedge clock) begin
      if (do_write) begin
         palette_mem_ff[addr] <= {q_cmd.red, q_cmd.green, q_cmd.blue};
      end
      if (q_pop) begin
         s1_entry_ff <= palette_mem_ff[addr];
      end
   end

   // Entry valid bits; an entry never written reads as zero levels.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PALETTE_ENTRIES; i++) begin
            entry_valid_ff[i] <= 1'b0;
         end
      end else if (do_write) begin
         entry_valid_ff[addr] <= 1'b1;
      end
   end

   // Lookup stage.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_ready) begin
         s1_valid_in = q_pop && !is_write;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_kind_ff  <= q_cmd.kind;
         s1_index_ff <= q_cmd.index;
         s1_hit_ff   <= q_cmd.in_range && entry_valid_ff[addr];
      end
   end

   // Result formatting.
   assign levels = s1_hit_ff ? s1_entry_ff : '0;

   always_comb begin
      rsp_data_in = '0;
      if (s1_kind_ff == KIND_READ) begin
         rsp_data_in.red   = levels[3*LEVEL_W-1:2*LEVEL_W];
         rsp_data_in.green = levels[2*LEVEL_W-1:LEVEL_W];
         rsp_data_in.blue  = levels[LEVEL_W-1:0];
      end else begin
         rsp_data_in.pixel = convert(color_mode, swap_bytes, s1_index_ff,
                                     levels[3*LEVEL_W-1:2*LEVEL_W],
                                     levels[2*LEVEL_W-1:LEVEL_W],
                                     levels[LEVEL_W-1:0]);
      end
      rsp_valid_in = out_ready ? s1_valid_ff : rsp_valid_ff;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = rsp_data_ff;

endmodule
